// ===== sv/smrp_pkg.sv =====
// ============================================================================
// smrp_pkg - shared types and constants for the row parallax shifter
// Beat payloads, configuration view and the work entry passed front to back.
// ============================================================================
package smrp_pkg;

    localparam int ColW  = 13;
    localparam int ValW  = 16;
    localparam int GainW = 24;
    localparam int HgtW  = 16;
    localparam int IdxW  = 3;

    localparam logic [IdxW-1:0] CFG_REVERSE    = 3'd0;
    localparam logic [IdxW-1:0] CFG_GAIN       = 3'd1;
    localparam logic [IdxW-1:0] CFG_REF_HEIGHT = 3'd2;
    localparam logic [IdxW-1:0] CFG_COL_OFFSET = 3'd3;
    localparam logic [IdxW-1:0] CFG_IN_COLS    = 3'd4;
    localparam logic [IdxW-1:0] CFG_EXT_COLS   = 3'd5;

    typedef struct packed {
        logic [ValW-1:0]        pixel_value;
        logic signed [HgtW-1:0] terrain_height;
        logic                   height_valid;
        logic                   row_last;
    } t_pixel;

    typedef struct packed {
        logic [ColW-1:0] run_start;
        logic [ColW-1:0] run_length;
        logic [ValW-1:0] run_value;
        logic            run_undefined;
        logic            row_done;
    } t_run;

    typedef struct packed {
        logic                    reverse;
        logic signed [GainW-1:0] gain;
        logic signed [HgtW-1:0]  ref_height;
        logic [ColW-1:0]         col_offset;
        logic [ColW-1:0]         in_cols;
        logic [ColW-1:0]         ext;
    } t_cfg;

    typedef struct packed {
        logic [ColW-1:0] proj;
        logic [ValW-1:0] value;
        logic            proj_ok;
        logic            first;
        logic            row_end;
    } t_work;

endpackage

// ===== sv/stereo_mate_row_parallax_shift.sv =====
// ============================================================================
// stereo_mate_row_parallax_shift - stereo mate row parallax shifter
// Projects a row of pixels by height parallax and emits filled column runs.
// Path: a pixel passes the front stage registers, the queue and the output register.
// Throughput: one pixel per cycle while the output is ready; a pixel holds the
// back for each run it emits, and one that starts and ends a row emits three.
// Reset: synchronous, active low; clears counters, queue and output register,
// and loads configuration defaults (input and extended columns at 1).
// ============================================================================
module stereo_mate_row_parallax_shift #(
    parameter int MAX_COLUMNS = 8191,
    parameter int PIXEL_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  smrp_pkg::t_pixel             i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output smrp_pkg::t_run               o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [smrp_pkg::IdxW-1:0]    i_cfg_index,
    input  logic [smrp_pkg::GainW-1:0]   i_cfg_data
);
    import smrp_pkg::*;

    localparam logic [16:0] MaxCols = 17'(MAX_COLUMNS);

    logic                    r_reverse;
    logic signed [GainW-1:0] r_gain;
    logic signed [HgtW-1:0]  r_ref_height;
    logic [ColW-1:0]         r_col_offset;
    logic [ColW-1:0]         r_in_cols;
    logic [ColW-1:0]         r_ext_cols;

    t_cfg                    cfg;
    logic                    push_valid;
    logic                    push_ready;
    t_work                   push_data;
    logic                    pop_valid;
    logic                    pop_ready;
    t_work                   pop_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse    <= 1'b0;
            r_gain       <= '0;
            r_ref_height <= '0;
            r_col_offset <= '0;
            r_in_cols    <= 13'd1;
            r_ext_cols   <= 13'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_REVERSE:    r_reverse    <= i_cfg_data[0];
                CFG_GAIN:       r_gain       <= $signed(i_cfg_data);
                CFG_REF_HEIGHT: r_ref_height <= $signed(i_cfg_data[HgtW-1:0]);
                CFG_COL_OFFSET: r_col_offset <= i_cfg_data[ColW-1:0];
                CFG_IN_COLS:    r_in_cols    <= i_cfg_data[ColW-1:0];
                CFG_EXT_COLS:   r_ext_cols   <= i_cfg_data[ColW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.reverse    = r_reverse;
        cfg.gain       = r_gain;
        cfg.ref_height = r_ref_height;
        cfg.col_offset = r_col_offset;
        cfg.in_cols    = r_in_cols;
        cfg.ext        = ({4'b0, r_ext_cols} < MaxCols) ? r_ext_cols : MaxCols[ColW-1:0];
    end

    smrp_front #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    smrp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    smrp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_data  (pop_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== sv/smrp_front.sv =====
// ============================================================================
// smrp_front - pixel intake and projection
// Counts columns, detects row ends, multiplies gain by height difference and
// floors/clamps the shifted column before handing a work entry to the queue.
// ============================================================================
module smrp_front #(
    parameter int PIXEL_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  smrp_pkg::t_cfg   i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  smrp_pkg::t_pixel i_in_data,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output smrp_pkg::t_work  o_push_data
);
    import smrp_pkg::*;

    localparam logic [ValW-1:0] PixMask =
        (PIXEL_BITS >= ValW) ? {ValW{1'b1}} : ValW'((32'd1 << PIXEL_BITS) - 32'd1);

    logic [ColW-1:0]      r_in_col;
    logic                 r_first;

    logic                 r_s1_valid;
    logic signed [15:0]   r_s1_base;
    logic signed [16:0]   r_s1_dz;
    logic [ValW-1:0]      r_s1_value;
    logic                 r_s1_ok;
    logic                 r_s1_first;
    logic                 r_s1_end;

    logic                 r_s2_valid;
    logic signed [15:0]   r_s2_base;
    logic signed [40:0]   r_s2_prod;
    logic [ValW-1:0]      r_s2_value;
    logic                 r_s2_ok;
    logic                 r_s2_first;
    logic                 r_s2_end;

    logic                 s1_ready;
    logic                 s2_ready;
    logic                 in_acc;
    logic                 row_end;
    logic signed [15:0]   col;
    logic signed [15:0]   base;
    logic signed [16:0]   dz;
    logic signed [40:0]   prod;
    logic signed [41:0]   pos;
    logic signed [25:0]   c;
    logic signed [25:0]   lim;
    logic [ColW-1:0]      cl;
    logic [ColW-1:0]      q;

    assign s2_ready   = !r_s2_valid || i_push_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;
    assign in_acc     = i_in_valid && s1_ready;

    assign row_end = i_in_data.row_last
                  || (({1'b0, r_in_col} + 14'd1) >= {1'b0, i_cfg.in_cols});

    assign col  = i_cfg.reverse
                ? $signed({3'b0, i_cfg.in_cols}) - 16'sd1 - $signed({3'b0, r_in_col})
                : $signed({3'b0, r_in_col});
    assign base = col + $signed({3'b0, i_cfg.col_offset});
    assign dz   = $signed({i_in_data.terrain_height[HgtW-1], i_in_data.terrain_height})
                - $signed({i_cfg.ref_height[HgtW-1], i_cfg.ref_height});

    assign prod = 41'(r_s1_dz) * 41'(i_cfg.gain);

    assign pos = 42'($signed({r_s2_base, 16'h0000})) - 42'(r_s2_prod);
    assign c   = pos[41:16];
    assign lim = $signed({13'b0, i_cfg.ext}) - 26'sd1;

    always_comb begin
        if (c < 26'sd0) begin
            cl = '0;
        end else if (c > lim) begin
            cl = lim[ColW-1:0];
        end else begin
            cl = c[ColW-1:0];
        end
        q = i_cfg.reverse ? (i_cfg.ext - 13'd1 - cl) : cl;
    end

    assign o_push_valid        = r_s2_valid;
    assign o_push_data.proj    = q;
    assign o_push_data.value   = r_s2_value;
    assign o_push_data.proj_ok = r_s2_ok;
    assign o_push_data.first   = r_s2_first;
    assign o_push_data.row_end = r_s2_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_first    <= 1'b1;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_in_col <= row_end ? '0 : r_in_col + 13'd1;
                r_first  <= row_end;
            end
            if (s1_ready) begin
                r_s1_valid <= in_acc;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_base  <= base;
            r_s1_dz    <= dz;
            r_s1_value <= i_in_data.pixel_value & PixMask;
            r_s1_ok    <= i_in_data.height_valid && (i_cfg.ext != '0);
            r_s1_first <= r_first;
            r_s1_end   <= row_end;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_base  <= r_s1_base;
            r_s2_prod  <= prod;
            r_s2_value <= r_s1_value;
            r_s2_ok    <= r_s1_ok;
            r_s2_first <= r_s1_first;
            r_s2_end   <= r_s1_end;
        end
    end

endmodule

// ===== sv/smrp_queue.sv =====
// ============================================================================
// smrp_queue - work entry queue
// Four-entry register queue that decouples projection from run emission.
// ============================================================================
module smrp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  smrp_pkg::t_work i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output smrp_pkg::t_work o_pop_data
);
    import smrp_pkg::*;

    localparam int Depth = 4;
    localparam int AW    = $clog2(Depth);

    t_work         r_mem [Depth];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_count != (AW+1)'(Depth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

// ===== sv/smrp_back.sv =====
// ============================================================================
// smrp_back - run emission
// Walks each work entry through leading, pixel and trailing runs against the
// output pointer, one run beat per cycle while the output register is free.
// ============================================================================
module smrp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  smrp_pkg::t_cfg  i_cfg,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  smrp_pkg::t_work i_pop_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output smrp_pkg::t_run  o_out_data
);
    import smrp_pkg::*;

    typedef enum logic [1:0] {PH_LEAD, PH_PIX, PH_TAIL} t_phase;

    t_phase          r_phase;
    logic [13:0]     r_done;
    logic            r_any;
    logic            r_out_valid;
    t_run            r_out;

    t_work           w;
    logic            out_free;
    logic            step;
    logic [13:0]     ext14;
    logic [13:0]     q14;
    logic            lead_en;
    logic            pix_en;
    logic            tail_en;
    logic            mark_en;
    logic            tail_after_pix;
    logic [ColW-1:0] start;
    logic            emit;
    logic            last;
    logic [13:0]     n_done;
    t_phase          n_phase;
    t_run            n_out;

    assign w        = i_pop_data;
    assign out_free = !r_out_valid || i_out_ready;
    assign step     = i_pop_valid && out_free;
    assign ext14    = {1'b0, i_cfg.ext};
    assign q14      = {1'b0, w.proj};

    assign lead_en = (r_phase == PH_LEAD) && w.proj_ok && w.first && (q14 > r_done);
    assign pix_en  = ((r_phase == PH_LEAD) || (r_phase == PH_PIX)) && w.proj_ok
                  && (q14 >= r_done) && (r_done < ext14);
    assign tail_en = w.row_end && (r_done < ext14);
    assign mark_en = w.row_end && !r_any;
    assign tail_after_pix = w.row_end && ((q14 + 14'd1) < ext14);
    assign start   = i_cfg.reverse ? (i_cfg.ext - 13'd1 - r_done[ColW-1:0])
                                   : r_done[ColW-1:0];

    always_comb begin
        emit    = 1'b0;
        last    = 1'b1;
        n_done  = r_done;
        n_phase = PH_LEAD;
        n_out   = '0;
        priority if (lead_en) begin
            emit                = 1'b1;
            last                = 1'b0;
            n_done              = q14;
            n_phase             = PH_PIX;
            n_out.run_start     = start;
            n_out.run_length    = 13'(q14 - r_done);
            n_out.run_undefined = 1'b1;
        end else if (pix_en) begin
            emit             = 1'b1;
            last             = !tail_after_pix;
            n_done           = q14 + 14'd1;
            n_phase          = PH_TAIL;
            n_out.run_start  = start;
            n_out.run_length = 13'(q14 - r_done + 14'd1);
            n_out.run_value  = w.value;
            n_out.row_done   = w.row_end && !tail_after_pix;
        end else if (tail_en) begin
            emit                = 1'b1;
            n_out.run_start     = start;
            n_out.run_length    = 13'(ext14 - r_done);
            n_out.run_undefined = 1'b1;
            n_out.row_done      = 1'b1;
        end else if (mark_en) begin
            emit                = 1'b1;
            n_out.run_undefined = 1'b1;
            n_out.row_done      = 1'b1;
        end else begin
            emit = 1'b0;
        end
    end

    assign o_pop_ready = out_free && last;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_done      <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                if (last) begin
                    r_phase <= PH_LEAD;
                    r_any   <= 1'b0;
                    r_done  <= w.row_end ? '0 : n_done;
                end else begin
                    r_phase <= n_phase;
                    r_any   <= 1'b1;
                    r_done  <= n_done;
                end
            end
            if (step && emit) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_marker_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.run_length == '0)
        |-> o_out_data.run_undefined && o_out_data.row_done)
        else $error("zero-length run that is not a row-end marker");

    a_row_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && last && w.row_end |=> (r_done == '0) && (r_phase == PH_LEAD))
        else $error("pointer not cleared after row end");

    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_LEAD) |-> i_pop_valid)
        else $error("work entry left mid-way through its runs");
`endif

endmodule

// ===== verif/testbench.sv =====
// ============================================================================
// testbench - stereo mate row parallax shifter
// Streams pixel rows through the shifter under directed and random settings,
// predicts every run beat from a shadow of the row state and checks each one
// as it leaves the block, with random sender gaps and receiver stalls.
// ============================================================================
module testbench;
    import smrp_pkg::*;

    localparam int MaxCols    = 8191;
    localparam int Settle     = 12;
    localparam int StallLimit = 2000;
    localparam logic [IdxW-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [IdxW-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {RX_OPEN, RX_DUTY, RX_COIN, RX_SKIP} t_rx_mode;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_pixel           i_in_data;
    logic             o_out_valid;
    logic             i_out_ready = 1'b1;
    t_run             o_out_data;
    logic             i_cfg_valid;
    logic             o_cfg_ready;
    logic [IdxW-1:0]  i_cfg_index;
    logic [GainW-1:0] i_cfg_data;

    logic                    cfg_reverse;
    logic signed [GainW-1:0] cfg_gain;
    logic signed [HgtW-1:0]  cfg_refh;
    logic [ColW-1:0]         cfg_offset;
    logic [ColW-1:0]         cfg_in_cols;
    logic [ColW-1:0]         cfg_ext;
    logic [13:0]             fill_ptr;
    logic [ColW-1:0]         in_col;
    logic                    row_start;

    t_run     projected_runs[$];
    t_run     want;
    int       bad_runs = 0;
    int       idle_cycles = 0;
    int       burst_left = 0;
    int       row_goal = 1;
    logic     sender_gaps = 1'b1;
    int       rx_tick = 0;
    int       rx_period = 2;
    int       rx_duty = 1;
    t_rx_mode rx_mode = RX_OPEN;

    stereo_mate_row_parallax_shift dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_run make_run(input longint start, input longint len,
                                      input logic [ValW-1:0] value, input logic undef);
        t_run r;
        r.run_start     = start[ColW-1:0];
        r.run_length    = len[ColW-1:0];
        r.run_value     = value;
        r.run_undefined = undef;
        r.row_done      = 1'b0;
        return r;
    endfunction

    function automatic t_pixel pix(input logic [ValW-1:0] value, input int height,
                                   input logic valid, input logic last);
        t_pixel px;
        px.pixel_value    = value;
        px.terrain_height = height[HgtW-1:0];
        px.height_valid   = valid;
        px.row_last       = last;
        return px;
    endfunction

    function automatic void project_pixel(input t_pixel px);
        t_run                   res [0:2];
        int                     n;
        int                     i;
        longint                 ext, col, pos, c, q, done;
        logic signed [HgtW-1:0] h;
        n    = 0;
        h    = px.terrain_height;
        ext  = (cfg_ext < MaxCols) ? longint'(cfg_ext) : longint'(MaxCols);
        done = longint'(fill_ptr);
        col  = cfg_reverse ? longint'(cfg_in_cols) - 1 - longint'(in_col) : longint'(in_col);
        if (px.height_valid && ext > 0) begin
            pos = (col + longint'(cfg_offset)) * 65536
                  - longint'(cfg_gain) * (longint'(h) - longint'(cfg_refh));
            c = pos >>> 16;
            if (c < 0) c = 0;
            if (c > ext - 1) c = ext - 1;
            q = cfg_reverse ? ext - 1 - c : c;
            if (row_start && q > done) begin
                res[n] = make_run(cfg_reverse ? ext - 1 - done : done, q - done, '0, 1'b1);
                n++;
                done = q;
            end
            if (q >= done && done < ext) begin
                res[n] = make_run(cfg_reverse ? ext - 1 - done : done, q - done + 1,
                                  px.pixel_value, 1'b0);
                n++;
                done = q + 1;
            end
        end
        row_start = 1'b0;
        if (px.row_last || longint'(in_col) + 1 >= longint'(cfg_in_cols)) begin
            if (done < ext) begin
                res[n] = make_run(cfg_reverse ? ext - 1 - done : done, ext - done, '0, 1'b1);
                n++;
            end
            if (n == 0) begin
                res[n] = make_run(0, 0, '0, 1'b1);
                n++;
            end
            res[n-1].row_done = 1'b1;
            fill_ptr  = '0;
            in_col    = '0;
            row_start = 1'b1;
        end else begin
            fill_ptr = done[13:0];
            in_col   = in_col + 1'b1;
        end
        for (i = 0; i < n; i++) projected_runs.push_back(res[i]);
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel px;
        if (in_col == 0) begin
            row_goal = (cfg_in_cols != 0 && cfg_in_cols <= 32) ? int'(cfg_in_cols)
                                                                : $urandom_range(1, 16);
            if ($urandom_range(0, 7) == 0) row_goal = $urandom_range(1, row_goal);
        end
        if ($urandom_range(0, 9) == 0) begin
            px.pixel_value    = 16'($urandom);
            px.terrain_height = 16'($urandom);
            px.height_valid   = 1'($urandom);
            px.row_last       = 1'($urandom);
        end else begin
            px.pixel_value    = 16'($urandom);
            px.terrain_height = 16'(int'(cfg_refh) + int'($urandom_range(0, 16)) - 8);
            px.height_valid   = $urandom_range(0, 12) != 0;
            px.row_last       = (int'(in_col) + 1 >= row_goal) || ($urandom_range(0, 39) == 0);
        end
        return px;
    endfunction

    task automatic send_pixel(input t_pixel px);
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (!o_in_ready);
        project_pixel(px);
        @(negedge i_clk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (sender_gaps) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [GainW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_REVERSE:    cfg_reverse = data[0];
            CFG_GAIN:       cfg_gain    = data;
            CFG_REF_HEIGHT: cfg_refh    = data[HgtW-1:0];
            CFG_COL_OFFSET: cfg_offset  = data[ColW-1:0];
            CFG_IN_COLS:    cfg_in_cols = data[ColW-1:0];
            CFG_EXT_COLS:   cfg_ext     = data[ColW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_config(input logic rev, input logic [GainW-1:0] gain,
                               input logic [HgtW-1:0] refh, input logic [ColW-1:0] off,
                               input logic [ColW-1:0] in_cols, input logic [ColW-1:0] ext);
        write_reg(CFG_REVERSE, {23'($urandom), rev});
        write_reg(CFG_GAIN, gain);
        write_reg(CFG_REF_HEIGHT, {8'($urandom), refh});
        write_reg(CFG_COL_OFFSET, {11'($urandom), off});
        write_reg(CFG_IN_COLS, {11'($urandom), in_cols});
        write_reg(CFG_EXT_COLS, {11'($urandom), ext});
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 24'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // hold input, wait out all expected beats, then let the pipe empty
    task automatic drain_runs(input int extra);
        i_in_valid <= 1'b0;
        while (projected_runs.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic random_config();
        logic [GainW-1:0] gain;
        logic [HgtW-1:0]  refh;
        logic [ColW-1:0]  off, ins, ext;
        gain = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                           : 24'($urandom_range(0, 524288) - 262144);
        refh = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200) - 100);
        case ($urandom_range(0, 9))
            0:       off = 13'($urandom);
            1:       off = '0;
            default: off = 13'($urandom_range(0, 8));
        endcase
        case ($urandom_range(0, 19))
            0:       ins = '0;
            1, 2:    ins = 13'($urandom);
            default: ins = 13'($urandom_range(1, 24));
        endcase
        case ($urandom_range(0, 19))
            0:       ext = '0;
            1, 2, 3: ext = 13'($urandom);
            default: ext = 13'($urandom_range(1, 48));
        endcase
        load_config(1'($urandom), gain, refh, off, ins, ext);
    endtask

    task automatic test_reset_defaults();
        send_pixel(pix(16'h1234, 0, 1'b1, 1'b0));
        send_pixel(pix(16'h0000, -1, 1'b0, 1'b0));
    endtask

    task automatic test_forward_rows();
        drain_runs(Settle);
        load_config(1'b0, 24'h010000, 16'h0000, 13'd2, 13'd6, 13'd12);
        send_pixel(pix(16'h0000, 0, 1'b1, 1'b0));
        send_pixel(pix(16'hFFFF, -3, 1'b1, 1'b0));
        send_pixel(pix(16'h1111, 0, 1'b0, 1'b0));
        send_pixel(pix(16'h2222, 5, 1'b1, 1'b0));
        send_pixel(pix(16'h3333, 32767, 1'b1, 1'b0));
        send_pixel(pix(16'h4444, -32768, 1'b1, 1'b0));
        send_pixel(pix(16'h5555, 0, 1'b0, 1'b0));
        send_pixel(pix(16'h6666, 0, 1'b1, 1'b1));
        send_pixel(pix(16'h7777, 0, 1'b0, 1'b1));
        send_pixel(pix(16'h8888, -32768, 1'b1, 1'b0));
        send_pixel(pix(16'h9999, 0, 1'b1, 1'b1));
    endtask

    task automatic test_reverse_rows();
        drain_runs(Settle);
        load_config(1'b1, 24'h010000, 16'h0000, 13'd2, 13'd6, 13'd12);
        send_pixel(pix(16'h00FF, 0, 1'b1, 1'b0));
        send_pixel(pix(16'hFF00, 2, 1'b1, 1'b0));
        send_pixel(pix(16'hAAAA, -4, 1'b1, 1'b1));
    endtask

    task automatic test_extremes();
        drain_runs(Settle);
        load_config(1'b0, 24'h7FFFFF, 16'h8000, 13'd8191, 13'd8191, 13'd8191);
        send_pixel(pix(16'h5555, 32767, 1'b1, 1'b0));
        send_pixel(pix(16'hFFFF, -32768, 1'b1, 1'b1));
        drain_runs(Settle);
        load_config(1'b1, 24'h800000, 16'h7FFF, 13'd8191, 13'd8191, 13'd8191);
        send_pixel(pix(16'h0001, -32768, 1'b1, 1'b0));
        send_pixel(pix(16'h0002, 32767, 1'b1, 1'b1));
        // zero width: markers only
        drain_runs(Settle);
        load_config(1'b0, 24'h010000, 16'h0000, 13'd0, 13'd4, 13'd0);
        send_pixel(pix(16'h0003, 0, 1'b1, 1'b0));
        send_pixel(pix(16'h0004, 0, 1'b1, 1'b1));
        // zero input columns: every pixel ends its row
        drain_runs(Settle);
        load_config(1'b0, 24'h000000, 16'h0000, 13'd0, 13'd0, 13'd5);
        send_pixel(pix(16'h0005, 0, 1'b1, 1'b0));
        send_pixel(pix(16'h0006, 0, 1'b0, 1'b0));
        // shrink the row width with the pointer already past it
        drain_runs(Settle);
        load_config(1'b0, 24'h000000, 16'h0000, 13'd0, 13'd6, 13'd12);
        send_pixel(pix(16'h0007, 0, 1'b1, 1'b0));
        send_pixel(pix(16'h0008, 0, 1'b1, 1'b0));
        drain_runs(Settle);
        load_config(1'b0, 24'h000000, 16'h0000, 13'd0, 13'd6, 13'd1);
        send_pixel(pix(16'h0009, 0, 1'b1, 1'b0));
        send_pixel(pix(16'h000A, 0, 1'b1, 1'b1));
    endtask

    task automatic test_random_rows(input int count);
        int sent;
        int span;
        sent = 0;
        while (sent < count) begin
            drain_runs(Settle);
            random_config();
            sender_gaps = $urandom_range(0, 3) != 0;
            span = $urandom_range(8, 40);
            repeat (span) begin
                if (sent < count) begin
                    send_pixel(random_pixel());
                    sent++;
                end
            end
        end
    endtask

    task automatic test_sender_pause();
        drain_runs(Settle);
        random_config();
        sender_gaps = 1'b1;
        repeat (15) send_pixel(random_pixel());
        drain_runs(0);
        repeat (15) send_pixel(random_pixel());
    endtask

    always @(negedge i_clk) begin
        if (rx_tick % 48 == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            rx_period = $urandom_range(2, 7);
            rx_duty   = $urandom_range(1, rx_period - 1);
        end
        rx_tick++;
        case (rx_mode)
            RX_OPEN: i_out_ready <= 1'b1;
            RX_DUTY: i_out_ready <= (rx_tick % rx_period) < rx_duty;
            RX_COIN: i_out_ready <= 1'($urandom);
            default: i_out_ready <= (rx_tick % rx_period) != 0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (projected_runs.size() == 0) begin
                bad_runs++;
                if (bad_runs <= 10)
                    $display("unexpected run beat: start %0d len %0d value %h undef %b done %b",
                             o_out_data.run_start, o_out_data.run_length,
                             o_out_data.run_value, o_out_data.run_undefined,
                             o_out_data.row_done);
            end else begin
                want = projected_runs.pop_front();
                if (o_out_data.run_start !== want.run_start ||
                    o_out_data.run_length !== want.run_length ||
                    o_out_data.run_value !== want.run_value ||
                    o_out_data.run_undefined !== want.run_undefined ||
                    o_out_data.row_done !== want.row_done) begin
                    bad_runs++;
                    if (bad_runs <= 10)
                        $display("run mismatch: exp %0d/%0d/%h/%b/%b got %0d/%0d/%h/%b/%b",
                                 want.run_start, want.run_length, want.run_value,
                                 want.run_undefined, want.row_done,
                                 o_out_data.run_start, o_out_data.run_length,
                                 o_out_data.run_value, o_out_data.run_undefined,
                                 o_out_data.row_done);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= StallLimit) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_REVERSE;
        i_cfg_data  <= '0;
        cfg_reverse = 1'b0;
        cfg_gain    = '0;
        cfg_refh    = '0;
        cfg_offset  = '0;
        cfg_in_cols = 13'd1;
        cfg_ext     = 13'd1;
        fill_ptr    = '0;
        in_col      = '0;
        row_start   = 1'b1;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_defaults();
        test_forward_rows();
        test_reverse_rows();
        test_extremes();
        test_random_rows(170);
        test_sender_pause();
        drain_runs(20);
        if (bad_runs == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/smrp_pkg.sv
sv/smrp_front.sv
sv/smrp_queue.sv
sv/smrp_back.sv
sv/stereo_mate_row_parallax_shift.sv
verif/testbench.sv
